// ===== rtl/core/metrics_text_line_tokenizer_top_macros.svh =====
// ----------------------------------------------------------------------------
// metrics text line tokenizer assertion macros
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef METRICS_TEXT_LINE_TOKENIZER_TOP_MACROS_SVH
`define METRICS_TEXT_LINE_TOKENIZER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define MLTT_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define MLTT_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/mltt_pkg.sv =====
// ----------------------------------------------------------------------------
// mltt_pkg
// shared types, character codes and helpers of the text line tokenizer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mltt_pkg;

   localparam int POSITION_WIDTH = 16;
   localparam int SPAN_WIDTH     = 16;
   localparam int FIFO_DEPTH     = 4;
   localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;

   localparam logic [1:0] EV_NAME  = 2'd0;
   localparam logic [1:0] EV_LABEL = 2'd1;
   localparam logic [1:0] EV_VALUE = 2'd2;
   localparam logic [1:0] EV_END   = 2'd3;

   typedef logic [POSITION_WIDTH-1:0] pos_type;
   typedef logic [SPAN_WIDTH-1:0]     span_type;

   typedef struct packed {
      logic [1:0] kind;
      span_type   first_start;
      span_type   first_length;
      span_type   second_start;
      span_type   second_length;
      logic       overflow;
      logic       last;
   } event_type;

   // up to two events from one byte; second is valid only with the first
   typedef struct packed {
      logic      valid0;
      logic      valid1;
      event_type ev0;
      event_type ev1;
   } evt_pair_type;

   function automatic span_type span_of(input pos_type p);
      return SPAN_WIDTH'(p);
   endfunction

   function automatic span_type span_len(input pos_type s, input pos_type e);
      return span_of(e) - span_of(s);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic logic is_eol(input logic [7:0] c);
      return (c == CH_CR) || (c == CH_LF) || (c == CH_NUL);
   endfunction

endpackage

// ===== rtl/core/mltt_parser.sv =====
// ----------------------------------------------------------------------------
// mltt_parser
// input register and one-byte parser step producing up to two events
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mltt_parser
   import mltt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_byte,
   input  logic         req_sot,
   input  logic         room,
   output evt_pair_type pair
);

   typedef enum logic [11:0] {
      PS_LINE_START   = 12'b0000_0000_0001,
      PS_COMMENT      = 12'b0000_0000_0010,
      PS_NAME         = 12'b0000_0000_0100,
      PS_LABEL_OR_VAL = 12'b0000_0000_1000,
      PS_LNAME_START  = 12'b0000_0001_0000,
      PS_LNAME        = 12'b0000_0010_0000,
      PS_EXPECT_EQ    = 12'b0000_0100_0000,
      PS_EXPECT_QUOTE = 12'b0000_1000_0000,
      PS_LVALUE       = 12'b0001_0000_0000,
      PS_LNAME_COMMA  = 12'b0010_0000_0000,
      PS_WAIT_VALUE   = 12'b0100_0000_0000,
      PS_VALUE        = 12'b1000_0000_0000
   } state_type;

   localparam pos_type POS_CAP = '1;

   logic       in_valid_ff;
   logic [7:0] byte_ff;
   logic       sot_ff;
   logic       fire;

   state_type  state_ff, state_in, state_c;
   pos_type    pos_ff, pos_in, pos_c, nxt;
   pos_type    tstart_ff, tstart_in, tstart_c;
   pos_type    tend_ff, tend_in, tend_c;
   pos_type    vstart_ff, vstart_in, vstart_c;
   pos_type    vend_ff, vend_in, vend_c;
   logic       fin_ff, fin_in, fin_c;
   logic       ovf_ff, ovf_in, ovf_c;
   logic       at_cap;
   logic       emit_name, emit_label, emit_value, emit_end;

   assign fire       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || room;

   // start of text clears everything ahead of this byte
   always_comb begin
      state_c  = sot_ff ? PS_LINE_START : state_ff;
      pos_c    = sot_ff ? '0 : pos_ff;
      tstart_c = sot_ff ? '0 : tstart_ff;
      tend_c   = sot_ff ? '0 : tend_ff;
      vstart_c = sot_ff ? '0 : vstart_ff;
      vend_c   = sot_ff ? '0 : vend_ff;
      fin_c    = sot_ff ? 1'b0 : fin_ff;
      ovf_c    = sot_ff ? 1'b0 : ovf_ff;
   end

   assign at_cap = (pos_c == POS_CAP);
   assign nxt    = at_cap ? POS_CAP : pos_c + 1'b1;

   always_comb begin
      state_in   = state_c;
      tstart_in  = tstart_c;
      tend_in    = tend_c;
      vstart_in  = vstart_c;
      vend_in    = vend_c;
      fin_in     = fin_c;
      ovf_in     = fin_c ? ovf_c : (ovf_c | at_cap);
      emit_name  = 1'b0;
      emit_label = 1'b0;
      emit_value = 1'b0;
      emit_end   = 1'b0;
      if (!fin_c) begin
         unique case (state_c)
            PS_COMMENT: begin
               if (byte_ff == CH_CR || byte_ff == CH_LF) state_in = PS_LINE_START;
               else if (byte_ff == CH_NUL) fin_in = 1'b1;
            end
            PS_NAME: begin
               if (is_blank(byte_ff) || byte_ff == CH_LBRACE) begin
                  state_in  = is_blank(byte_ff) ? PS_LABEL_OR_VAL : PS_LNAME_START;
                  emit_name = 1'b1;
               end else if (is_eol(byte_ff)) begin
                  state_in  = PS_LINE_START;
                  emit_name = 1'b1;
                  emit_end  = 1'b1;
               end else begin
                  tend_in = nxt;
               end
            end
            PS_LABEL_OR_VAL: begin
               if (byte_ff == CH_LBRACE) begin
                  state_in = PS_LNAME_START;
               end else if (is_eol(byte_ff)) begin
                  state_in = PS_LINE_START;
                  emit_end = 1'b1;
               end else if (!is_blank(byte_ff)) begin
                  state_in  = PS_VALUE;
                  tstart_in = pos_c;
                  tend_in   = nxt;
               end
            end
            PS_LNAME_START: begin
               if (is_blank(byte_ff)) begin
                  state_in = PS_LNAME_START;
               end else if (byte_ff == CH_RBRACE) begin
                  state_in = PS_WAIT_VALUE;
               end else if (is_eol(byte_ff)) begin
                  state_in = PS_LINE_START;
                  emit_end = 1'b1;
               end else begin
                  state_in  = PS_LNAME;
                  tstart_in = pos_c;
                  tend_in   = nxt;
               end
            end
            PS_LNAME: begin
               if (is_blank(byte_ff)) begin
                  state_in = PS_EXPECT_EQ;
               end else if (is_eol(byte_ff)) begin
                  state_in = PS_LINE_START;
                  emit_end = 1'b1;
               end else if (byte_ff == CH_EQUAL) begin
                  state_in = PS_EXPECT_QUOTE;
               end else begin
                  tend_in = nxt;
               end
            end
            PS_EXPECT_EQ: begin
               if (is_eol(byte_ff)) begin
                  state_in = PS_LINE_START;
                  emit_end = 1'b1;
               end else if (byte_ff == CH_EQUAL) begin
                  state_in = PS_EXPECT_QUOTE;
               end
            end
            PS_EXPECT_QUOTE: begin
               if (is_eol(byte_ff)) begin
                  state_in = PS_LINE_START;
                  emit_end = 1'b1;
               end else if (byte_ff == CH_QUOTE) begin
                  state_in  = PS_LVALUE;
                  vstart_in = nxt;
                  vend_in   = nxt;
               end
            end
            PS_LVALUE: begin
               // no escapes: a quote always closes the value
               if (is_eol(byte_ff)) begin
                  state_in = PS_LINE_START;
                  emit_end = 1'b1;
               end else if (byte_ff == CH_QUOTE) begin
                  state_in   = PS_LNAME_COMMA;
                  emit_label = 1'b1;
               end else begin
                  vend_in = nxt;
               end
            end
            PS_LNAME_COMMA: begin
               if (is_eol(byte_ff)) begin
                  state_in = PS_LINE_START;
                  emit_end = 1'b1;
               end else if (byte_ff == CH_COMMA) begin
                  state_in = PS_LNAME_START;
               end else if (byte_ff == CH_RBRACE) begin
                  state_in = PS_WAIT_VALUE;
               end
            end
            PS_WAIT_VALUE: begin
               if (is_eol(byte_ff)) begin
                  state_in = PS_LINE_START;
                  emit_end = 1'b1;
               end else if (!is_blank(byte_ff)) begin
                  state_in  = PS_VALUE;
                  tstart_in = pos_c;
                  tend_in   = nxt;
               end
            end
            PS_VALUE: begin
               if (is_eol(byte_ff)) begin
                  state_in   = PS_LINE_START;
                  emit_value = 1'b1;
                  emit_end   = 1'b1;
               end else begin
                  tend_in = nxt;
               end
            end
            default: begin
               // line start, and any code outside the list
               if (is_blank(byte_ff) || byte_ff == CH_CR || byte_ff == CH_LF) begin
                  state_in = PS_LINE_START;
               end else if (byte_ff == CH_NUL) begin
                  state_in = PS_LINE_START;
                  fin_in   = 1'b1;
               end else if (byte_ff == CH_HASH) begin
                  state_in = PS_COMMENT;
               end else begin
                  state_in  = PS_NAME;
                  tstart_in = pos_c;
                  tend_in   = nxt;
               end
            end
         endcase
      end
      pos_in = fin_in ? pos_c : nxt;
   end

   // event build: a span event comes first, the record end after it
   always_comb begin
      pair            = '0;
      pair.ev0.overflow = ovf_in;
      pair.ev1.overflow = ovf_in;
      pair.ev1.kind   = EV_END;
      pair.ev1.last   = 1'b1;
      if (emit_name || emit_value || emit_label) begin
         pair.valid0           = fire;
         pair.valid1           = fire && emit_end;
         pair.ev0.kind         = emit_name ? EV_NAME : (emit_value ? EV_VALUE : EV_LABEL);
         pair.ev0.first_start  = span_of(tstart_c);
         pair.ev0.first_length = span_len(tstart_c, tend_c);
         pair.ev0.last         = !emit_end;
         if (emit_label) begin
            pair.ev0.second_start  = span_of(vstart_c);
            pair.ev0.second_length = span_len(vstart_c, vend_c);
         end
      end else if (emit_end) begin
         pair.valid0   = fire;
         pair.ev0.kind = EV_END;
         pair.ev0.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= PS_LINE_START;
         pos_ff      <= '0;
         tstart_ff   <= '0;
         tend_ff     <= '0;
         vstart_ff   <= '0;
         vend_ff     <= '0;
         fin_ff      <= 1'b0;
         ovf_ff      <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (fire) begin
            state_ff  <= state_in;
            pos_ff    <= pos_in;
            tstart_ff <= tstart_in;
            tend_ff   <= tend_in;
            vstart_ff <= vstart_in;
            vend_ff   <= vend_in;
            fin_ff    <= fin_in;
            ovf_ff    <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         byte_ff <= req_byte;
         sot_ff  <= req_sot;
      end
   end

endmodule

// ===== rtl/core/mltt_event_fifo.sv =====
// ----------------------------------------------------------------------------
// mltt_event_fifo
// small result queue taking up to two events per cycle, one out per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mltt_event_fifo
   import mltt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  evt_pair_type pair,
   output logic         room,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output event_type    rsp_event
);

   event_type               entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic [FIFO_PTR_W-1:0]   wr_ptr_next;
   logic [1:0]              push_n;
   logic                    pop;

   assign room        = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign rsp_tvalid  = (count_ff != '0);
   assign rsp_event   = entry_ff[rd_ptr_ff];
   assign pop         = rsp_tvalid && rsp_tready;
   assign push_n      = {1'b0, pair.valid0} + {1'b0, pair.valid1};
   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pair.valid0) entry_ff[wr_ptr_ff]   <= pair.ev0;
      if (pair.valid1) entry_ff[wr_ptr_next] <= pair.ev1;
   end

endmodule

// ===== rtl/core/metrics_text_line_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// metrics_text_line_tokenizer_top
// byte-stream tokenizer for metrics exposition text, reporting token spans
// ----------------------------------------------------------------------------
// usage:
//   - req channel: one text byte per request; req_tuser flags start of text,
//     which clears parser state and byte position ahead of that byte
//   - a byte of zero ends the content; inside a record it acts as
//     a line end, at line start or in a comment it silences the block until
//     the next start of text
//   - rsp channel: up to two events per request (name, label, value, record end),
//     with byte offsets and lengths; rsp_tlast marks the last event of a byte
//   - path: a byte sits in the input register, is parsed and its events are
//     written into a four-entry queue, which presents them on the rsp channel
//   - throughput: one byte per cycle while the queue holds at most two
//     events; for bytes yielding two events, the output port's one event per
//     cycle sets the rate
//   - reset: synchronous; clears the parser to line start, position zero,
//     and empties the queue
//   - stall: when the queue cannot take two more events the input register
//     holds and req_tready drops; queued events wait intact for rsp_tready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module metrics_text_line_tokenizer_top
   import mltt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tuser,   // [0] start_of_text
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [15:0] first_start, [31:16] first_length,
                                    // [47:32] second_start, [63:48] second_length,
                                    // [64] position_overflow, [71:65] zero
   output logic [1:0]  rsp_tuser,   // [1:0] event_kind
   output logic        rsp_tlast    // last_event
);

   localparam int DATA_USED = 4 * SPAN_WIDTH + 1;
   localparam int DATA_PAD  = 72 - DATA_USED;

   evt_pair_type pair;
   event_type    rsp_event;
   logic         room;

   // input register and parser step
   mltt_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .req_sot    (req_tuser),
      .room       (room),
      .pair       (pair)
   );

   // result queue decouples the parser from the receiver
   mltt_event_fifo u_event_fifo (
      .clock      (clock),
      .reset      (reset),
      .pair       (pair),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_event  (rsp_event)
   );

   // pack result fields, lowest first
   assign rsp_tdata = {{DATA_PAD{1'b0}},
                       rsp_event.overflow,
                       rsp_event.second_length,
                       rsp_event.second_start,
                       rsp_event.first_length,
                       rsp_event.first_start};
   assign rsp_tuser = rsp_event.kind;
   assign rsp_tlast = rsp_event.last;

endmodule

// ===== rtl/core/mltt_checker.sv =====
// ----------------------------------------------------------------------------
// mltt_checker
// port-level checks of the text line tokenizer, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "metrics_text_line_tokenizer_top_macros.svh"

module mltt_checker
   import mltt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   logic stalled;
   logic req_wait;
   logic is_end;
   logic is_label;

   assign stalled  = rsp_tvalid && !rsp_tready;
   assign req_wait = req_tvalid && !req_tready;
   assign is_end   = (rsp_tuser == EV_END);
   assign is_label = (rsp_tuser == EV_LABEL);

   // record end carries no spans
   `MLTT_ASSERT_IMP(a_end_no_span, clock, reset, rsp_tvalid && is_end, rsp_tdata[63:0] == '0, "record end with span")

   // only label events carry a value span
   `MLTT_ASSERT_IMP(a_second_label_only, clock, reset, rsp_tvalid && !is_label, rsp_tdata[63:32] == '0, "second span outside label")

   // a stalled result holds
   `MLTT_ASSERT_NXT(a_rsp_hold, clock, reset, stalled, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result changed")

   // a waiting request holds
   `MLTT_ASSERT_NXT(a_req_hold, clock, reset, req_wait, req_tvalid && $stable({req_tdata, req_tuser}), "waiting request changed")

   // queue is empty right after reset
   `MLTT_ASSERT_IMP(a_reset_empty, clock, reset, $past(reset), !rsp_tvalid, "result after reset")

endmodule

bind metrics_text_line_tokenizer_top mltt_checker u_mltt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== bench/tb_metrics_text_line_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// tb_metrics_text_line_tokenizer_top
// self-checking bench for the metrics text line tokenizer: text bytes go in
// as requests, a parser model in the bench predicts the span events, and
// every event leaving the block is compared field by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_metrics_text_line_tokenizer_top;
   import mltt_pkg::*;

   localparam int       CYCLE_LIMIT    = 2_000_000;
   localparam int       RANDOM_BYTES   = 1600;
   localparam pos_type  POS_CAP        = '1;

   // parser states of the model, same order as the block
   typedef enum logic [3:0] {
      PS_LINE_START, PS_COMMENT, PS_NAME, PS_LABEL_OR_VALUE, PS_LABEL_NAME_START,
      PS_LABEL_NAME, PS_EXPECT_EQUAL, PS_EXPECT_QUOTE, PS_LABEL_VALUE,
      PS_AFTER_LABEL, PS_WAIT_VALUE, PS_VALUE
   } parse_state_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] text_byte
   logic        req_tuser;    // [0] start_of_text
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;    // [15:0] first_start, [31:16] first_length,
                              // [47:32] second_start, [63:48] second_length,
                              // [64] position_overflow, [71:65] zero
   logic [1:0]  rsp_tuser;    // [1:0] event_kind
   logic        rsp_tlast;    // last_event

   // parser model state
   parse_state_type parse_st;
   pos_type      byte_pos, tok_start, tok_end, lval_start, lval_end;
   logic         parse_done, pos_overflowed;

   event_type    step_buf[2];
   int           step_n;
   event_type    expected_events[$];

   // run bookkeeping
   int  cycle_count = 0;
   int  mismatch_count = 0;
   int  bytes_taken = 0;
   int  events_seen = 0;
   int  input_stall_cycles = 0;
   int  overflow_events = 0;

   // idling controls, written by the test tasks only
   bit  send_idle = 1'b0;
   bit  rsp_idle = 1'b0;
   int  hold_off_len = 0;
   int  hold_off_serial = 0;

   // receiver-side counters, owned by the ready process
   int  hold_off_count = 0;
   int  hold_off_seen = 0;
   int  rsp_gap_left = 0;

   metrics_text_line_tokenizer_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // parser model
   // ---------------------------------------------------------------------
   task automatic clear_parser();
      parse_st       = PS_LINE_START;
      byte_pos       = '0;
      tok_start      = '0;
      tok_end        = '0;
      lval_start     = '0;
      lval_end       = '0;
      parse_done     = 1'b0;
      pos_overflowed = 1'b0;
   endtask

   // spans travel as offset plus length, cut to the span width
   function automatic void add_event(input logic [1:0] kind, input pos_type s1,
                                     input pos_type e1, input pos_type s2,
                                     input pos_type e2);
      event_type ev;
      ev.kind          = kind;
      ev.first_start   = SPAN_WIDTH'(s1);
      ev.first_length  = SPAN_WIDTH'(e1 - s1);
      ev.second_start  = SPAN_WIDTH'(s2);
      ev.second_length = SPAN_WIDTH'(e2 - s2);
      ev.overflow      = pos_overflowed;
      ev.last          = 1'b0;
      step_buf[step_n] = ev;
      step_n++;
   endfunction

   task automatic predict_byte(input logic [7:0] c, input logic sot);
      pos_type p, nx;
      logic    blank, eol;
      step_n = 0;
      blank  = (c == CH_SPACE) || (c == CH_TAB);
      eol    = (c == CH_CR) || (c == CH_LF) || (c == CH_NUL);
      if (sot) clear_parser();
      if (parse_done) return;
      p  = byte_pos;
      nx = (p == POS_CAP) ? POS_CAP : p + 1'b1;
      if (p == POS_CAP) pos_overflowed = 1'b1;

      // a line end inside a record closes it, whatever state it is in
      if (eol && parse_st != PS_LINE_START && parse_st != PS_COMMENT) begin
         if (parse_st == PS_NAME) add_event(EV_NAME, tok_start, tok_end, '0, '0);
         else if (parse_st == PS_VALUE) add_event(EV_VALUE, tok_start, tok_end, '0, '0);
         add_event(EV_END, '0, '0, '0, '0);
         parse_st = PS_LINE_START;
      end else begin
         case (parse_st)
            PS_COMMENT: begin
               if (c == CH_CR || c == CH_LF) parse_st = PS_LINE_START;
               else if (c == CH_NUL) parse_done = 1'b1;
            end
            PS_NAME: begin
               if (blank || c == CH_LBRACE) begin
                  parse_st = blank ? PS_LABEL_OR_VALUE : PS_LABEL_NAME_START;
                  add_event(EV_NAME, tok_start, tok_end, '0, '0);
               end else tok_end = nx;
            end
            PS_LABEL_OR_VALUE: begin
               if (c == CH_LBRACE) parse_st = PS_LABEL_NAME_START;
               else if (!blank) begin
                  parse_st  = PS_VALUE;
                  tok_start = p;
                  tok_end   = nx;
               end
            end
            PS_LABEL_NAME_START: begin
               if (c == CH_RBRACE) parse_st = PS_WAIT_VALUE;
               else if (!blank) begin
                  parse_st  = PS_LABEL_NAME;
                  tok_start = p;
                  tok_end   = nx;
               end
            end
            PS_LABEL_NAME: begin
               if (blank) parse_st = PS_EXPECT_EQUAL;
               else if (c == CH_EQUAL) parse_st = PS_EXPECT_QUOTE;
               else tok_end = nx;
            end
            PS_EXPECT_EQUAL: begin
               if (c == CH_EQUAL) parse_st = PS_EXPECT_QUOTE;
            end
            PS_EXPECT_QUOTE: begin
               if (c == CH_QUOTE) begin
                  parse_st   = PS_LABEL_VALUE;
                  lval_start = nx;
                  lval_end   = nx;
               end
            end
            PS_LABEL_VALUE: begin
               if (c == CH_QUOTE) begin
                  parse_st = PS_AFTER_LABEL;
                  add_event(EV_LABEL, tok_start, tok_end, lval_start, lval_end);
               end else lval_end = nx;
            end
            PS_AFTER_LABEL: begin
               if (c == CH_COMMA) parse_st = PS_LABEL_NAME_START;
               else if (c == CH_RBRACE) parse_st = PS_WAIT_VALUE;
            end
            PS_WAIT_VALUE: begin
               if (!blank) begin
                  parse_st  = PS_VALUE;
                  tok_start = p;
                  tok_end   = nx;
               end
            end
            PS_VALUE: tok_end = nx;
            default: begin
               if (blank || c == CH_CR || c == CH_LF) parse_st = PS_LINE_START;
               else if (c == CH_NUL) begin
                  parse_st   = PS_LINE_START;
                  parse_done = 1'b1;
               end else if (c == CH_HASH) parse_st = PS_COMMENT;
               else begin
                  parse_st  = PS_NAME;
                  tok_start = p;
                  tok_end   = nx;
               end
            end
         endcase
      end

      if (!parse_done) byte_pos = nx;
      if (step_n > 0) step_buf[step_n-1].last = 1'b1;
      for (int i = 0; i < step_n; i++) expected_events.push_back(step_buf[i]);
   endtask

   // every accepted request feeds the model
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         bytes_taken++;
         predict_byte(req_tdata, req_tuser);
      end
      if (!reset && req_tvalid && !req_tready) input_stall_cycles++;
   end

   // ---------------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------------
   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         events_seen++;
         if (rsp_tdata[64] === 1'b1) overflow_events++;
         if (expected_events.size() == 0) begin
            $error("event with nothing expected: kind %0d start %0d", rsp_tuser,
                   rsp_tdata[15:0]);
            mismatch_count++;
         end else begin
            want = expected_events.pop_front();
            check_field("event_kind", 16'(want.kind), 16'(rsp_tuser));
            check_field("first_start", want.first_start, rsp_tdata[15:0]);
            check_field("first_length", want.first_length, rsp_tdata[31:16]);
            check_field("second_start", want.second_start, rsp_tdata[47:32]);
            check_field("second_length", want.second_length, rsp_tdata[63:48]);
            check_field("position_overflow", 16'(want.overflow), 16'(rsp_tdata[64]));
            check_field("last_event", 16'(want.last), 16'(rsp_tlast));
            check_field("tdata padding", 16'd0, 16'(rsp_tdata[71:65]));
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver: random stalls, plus a long hold-off on request
   // ---------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   always @(posedge clock) begin
      int g;
      if (hold_off_serial != hold_off_seen) begin
         hold_off_seen  <= hold_off_serial;
         hold_off_count <= hold_off_len;
         rsp_tready     <= 1'b0;
      end else if (hold_off_count > 0) begin
         hold_off_count <= hold_off_count - 1;
         rsp_tready     <= 1'b0;
      end else if (rsp_gap_left > 0) begin
         rsp_gap_left <= rsp_gap_left - 1;
         rsp_tready   <= 1'b0;
      end else begin
         g = rsp_idle ? pick_gap() : 0;
         rsp_tready   <= (g == 0);
         rsp_gap_left <= (g > 0) ? g - 1 : 0;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------
   // valid stays high after acceptance so back-to-back requests need no gap
   task automatic send_byte(input logic [7:0] b, input logic sot);
      int gap;
      gap = send_idle ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= sot;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_string(input string s, input logic sot);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], sot && (i == 0));
   endtask

   // sender stops until every predicted event has left the block
   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_char(input string chars);
      return chars[$urandom_range(0, chars.len() - 1)];
   endfunction

   function automatic logic [7:0] pick_printable();
      logic [7:0] c;
      do c = 8'($urandom_range(32, 126)); while (c == CH_QUOTE);
      return c;
   endfunction

   // one random line: mostly well-formed records, some comments, blanks and
   // terminators, with a few bytes corrupted on the way out
   task automatic send_random_line(input logic sot, output int sent);
      logic [7:0] text[$];
      logic [7:0] b;
      int         kind, r;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         text.push_back(CH_HASH);
         repeat ($urandom_range(0, 12)) text.push_back(pick_printable());
      end else if (kind < 14) begin
         repeat ($urandom_range(1, 3)) text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      end else begin
         if ($urandom_range(0, 9) == 0) text.push_back(CH_SPACE);
         repeat ($urandom_range(1, 8)) text.push_back(pick_char("abcxyz_:AZ09"));
         if ($urandom_range(0, 99) < 60) begin
            if ($urandom_range(0, 4) == 0) text.push_back(CH_SPACE);
            text.push_back(CH_LBRACE);
            for (int l = $urandom_range(0, 3); l > 0; l--) begin
               if ($urandom_range(0, 4) == 0) text.push_back(CH_SPACE);
               repeat ($urandom_range(1, 5)) text.push_back(pick_char("lmnop_ABC7"));
               if ($urandom_range(0, 4) == 0) text.push_back(CH_TAB);
               text.push_back(CH_EQUAL);
               if ($urandom_range(0, 9) == 0) text.push_back(CH_SPACE);
               text.push_back(CH_QUOTE);
               repeat ($urandom_range(0, 6)) text.push_back(pick_printable());
               text.push_back(CH_QUOTE);
               if (l > 1) text.push_back(CH_COMMA);
            end
            if ($urandom_range(0, 4) == 0) text.push_back(CH_SPACE);
            text.push_back(CH_RBRACE);
         end
         if ($urandom_range(0, 99) < 70) begin
            repeat ($urandom_range(1, 2)) text.push_back(CH_SPACE);
            repeat ($urandom_range(1, 6)) text.push_back(pick_char("0123456789.e+-"));
         end
      end
      r = $urandom_range(0, 99);
      if (r < 70) text.push_back(CH_LF);
      else if (r < 82) text.push_back(CH_CR);
      else if (r < 94) begin
         text.push_back(CH_CR);
         text.push_back(CH_LF);
      end else text.push_back(CH_NUL);

      foreach (text[i]) begin
         b = text[i];
         r = $urandom_range(0, 99);
         if (r < 3) b = 8'($urandom_range(0, 255));
         else if (r < 5) b = CH_LF;
         send_byte(b, sot && (i == 0));
      end
      sent = text.size();
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   task automatic test_directed_lines();
      send_idle = 1'b1;
      rsp_idle  = 1'b1;
      // one of each event: name, label, value, record end
      send_string("a{b=\"c\"} 1\n", 1'b1);
      // comment line is skipped
      send_string("#x\n", 1'b0);
      // leading blank and tab, top byte value as a name, carriage return
      send_string(" \t", 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CH_CR, 1'b0);
      // terminator inside a record ends it like a line end
      send_string("v 9", 1'b0);
      send_byte(CH_NUL, 1'b0);
      // terminator at line start silences the block
      send_byte(CH_NUL, 1'b0);
      send_string("q 1\n", 1'b0);
      // start of text restarts it; terminator in a comment silences again
      send_string("#", 1'b1);
      send_byte(CH_NUL, 1'b0);
      send_string("r\n", 1'b0);
      pause_until_drained();
   endtask

   // receiver holds off while the sender keeps offering records
   task automatic test_input_backpressure();
      send_idle = 1'b0;
      rsp_idle  = 1'b0;
      hold_off_len = 400;
      hold_off_serial++;
      send_string("m{l=\"v\",k=\"w\"} 12\n", 1'b1);
      repeat (4) send_string("n{a=\"b\"} 3\nz\n", 1'b0);
      pause_until_drained();
   endtask

   task automatic test_random_text();
      int  total, sent, noise;
      bit  restart;
      total   = 0;
      restart = 1'b1;
      while (total < RANDOM_BYTES) begin
         // switch idling every few hundred bytes, sometimes none at all
         if ((total % 200) < 12) begin
            send_idle = ($urandom_range(0, 3) != 0);
            rsp_idle  = ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 99) < 4) begin
            // terminator at line start, then bytes the block must ignore
            send_byte(CH_NUL, restart);
            noise = $urandom_range(0, 3);
            repeat (noise) send_byte(8'($urandom_range(0, 255)), 1'b0);
            total++;
            restart = 1'b1;
         end else begin
            send_random_line(restart || ($urandom_range(0, 19) == 0), sent);
            total += sent;
            restart = 1'b0;
         end
      end
      pause_until_drained();
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      clear_parser();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_lines();
      test_input_backpressure();
      test_random_text();

      repeat (8) @(posedge clock);
      if (expected_events.size() != 0)
         $error("%0d expected events never arrived", expected_events.size());
      $display("covered %0d text bytes and %0d events, %0d of them past the position cap",
               bytes_taken, events_seen, overflow_events);
      $display("input held off for %0d cycles under output back-pressure",
               input_stall_cycles);
      if (mismatch_count == 0 && expected_events.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
